// ===== hdl/pfq_pkg.sv =====
// Shared constants, codes and types for the priority frame queue.
`default_nettype none
package pfq_pkg;

  localparam int PRIORITIES  = 8;
  localparam int QUEUE_DEPTH = 256;
  localparam int TAG_WIDTH   = 16;

  localparam int TAG_PORT_W  = 16;
  localparam int FBITS_W     = 14;
  localparam int FCNT_W      = 16;
  localparam int FWDB_W      = 32;

  localparam int PRIO_W      = (PRIORITIES > 1) ? $clog2(PRIORITIES) : 1;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int BT_W        = $clog2(QUEUE_DEPTH * (2 ** FBITS_W - 1) + 1);
  localparam int TC_W        = $clog2(PRIORITIES * QUEUE_DEPTH + 1);
  localparam int TB_W        = $clog2(PRIORITIES * QUEUE_DEPTH * (2 ** FBITS_W - 1) + 1);
  localparam int STORE_TAG_W = (TAG_WIDTH < TAG_PORT_W) ? TAG_WIDTH : TAG_PORT_W;
  localparam int ENTRY_W     = STORE_TAG_W + FBITS_W;
  localparam int ADDR_W      = PRIO_W + PTR_W;

  typedef enum logic [2:0] {
    CMD_INSERT   = 3'd0,
    CMD_FORWARD  = 3'd1,
    CMD_POP      = 3'd2,
    CMD_POP_PRIO = 3'd3,
    CMD_QUERY    = 3'd4
  } cmd_t;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_BAD_PRIO = 2'd1;
  localparam logic [1:0] ERR_FULL     = 2'd2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_NONSTRICT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POP_ONLY  = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic              found;
    logic              credited;
    logic [PRIO_W-1:0] q;
  } sel_t;

endpackage
`default_nettype wire

// ===== hdl/pfq_frame_ram.sv =====
// Single-port-write, registered-read frame store RAM.
`default_nettype none
module pfq_frame_ram #(
  parameter int DATA_W = 30,
  parameter int ADDR_W = 11
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/pfq_prio_select.sv =====
// Pop arbitration: credited search first when nonstrict is set, then plain strict priority unless pop_only is set.
`default_nettype none
module pfq_prio_select (
  input  wire logic [pfq_pkg::PRIORITIES-1:0] avail,
  input  wire logic [pfq_pkg::PRIORITIES-1:0] credit,
  input  wire logic                           nonstrict,
  input  wire logic                           pop_only,
  output pfq_pkg::sel_t                       sel
);
  import pfq_pkg::*;

  logic              cred_found;
  logic [PRIO_W-1:0] cred_q;
  logic              any_found;
  logic [PRIO_W-1:0] any_q;

  // scan from lowest priority up so index 0 wins last
  always_comb begin
    cred_found = 1'b0;
    cred_q     = '0;
    any_found  = 1'b0;
    any_q      = '0;
    for (int i = PRIORITIES - 1; i >= 0; i--) begin
      if (credit[i]) begin
        cred_found = 1'b1;
        cred_q     = PRIO_W'(i);
      end
      if (avail[i]) begin
        any_found = 1'b1;
        any_q     = PRIO_W'(i);
      end
    end
  end

  always_comb begin
    sel = '0;
    if (nonstrict && cred_found) begin
      sel.found    = 1'b1;
      sel.credited = 1'b1;
      sel.q        = cred_q;
    end else if (!pop_only && any_found) begin
      sel.found    = 1'b1;
      sel.credited = 1'b0;
      sel.q        = any_q;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/priority_frame_queue_with_report_credit_core.sv =====
// Top level: strict-priority frame queue with forwarded credit counters that can steer pops in nonstrict mode.
// Sequence: an accepted command passes EXEC and then RESP, where the result strobe
//   is shown; a pop that returns a frame also passes READ between them for the
//   registered frame RAM read.
// Commands: busy is high in EXEC and READ, so a new command is taken only once
//   the last one is through; a new command is taken in the strobe cycle.
// Reset: synchronous, active low; clears pointers, counters and config registers.
//   The frame RAM is not cleared. The receiver cannot stall results.
`default_nettype none
module priority_frame_queue_with_report_credit_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // command channel
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [2:0]                      in_cmd,
  input  wire logic [3:0]                      in_priority_req,
  input  wire logic [pfq_pkg::TAG_PORT_W-1:0]  in_frame_tag,
  input  wire logic [pfq_pkg::FBITS_W-1:0]     in_frame_bits,
  // result channel
  output logic                                 out_strobe,
  output logic                                 out_has_frame,
  output logic [pfq_pkg::TAG_PORT_W-1:0]       out_tag,
  output logic [pfq_pkg::FBITS_W-1:0]          out_bits,
  output logic [2:0]                           out_priority,
  output logic [1:0]                           out_error_code,
  output logic [8:0]                           out_prio_count,
  output logic [21:0]                          out_prio_bit_total,
  output logic [15:0]                          out_prio_fwd_count,
  output logic signed [31:0]                   out_prio_fwd_bits,
  output logic [11:0]                          out_total_count,
  output logic [24:0]                          out_total_bits,
  output logic                                 out_all_empty,
  // configuration write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pfq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic                            cfg_data
);
  import pfq_pkg::*;

  // ---------------------------------------------------------------------------
  // Control and per-priority queue state (all small, kept in flops)
  // ---------------------------------------------------------------------------
  state_t                    state_r, state_nxt;
  logic                      nonstrict_r;
  logic                      pop_only_r;

  logic [PTR_W-1:0]          head_r      [PRIORITIES];
  logic [PTR_W-1:0]          tail_r      [PRIORITIES];
  logic [CNT_W-1:0]          count_r     [PRIORITIES];
  logic [BT_W-1:0]           btot_r      [PRIORITIES];
  logic [FCNT_W-1:0]         fcnt_r      [PRIORITIES];
  logic signed [FWDB_W-1:0]  fwd_bits_r  [PRIORITIES];
  logic [TC_W-1:0]           total_cnt_r;
  logic [TB_W-1:0]           total_bits_r;

  // latched command transaction
  logic [2:0]                cmd_r;
  logic [3:0]                pr_r;
  logic [STORE_TAG_W-1:0]    tag_r;
  logic [FBITS_W-1:0]        fbits_r;

  // result held for the strobe cycle
  logic                      res_has_r;
  logic [STORE_TAG_W-1:0]    res_tag_r;
  logic [FBITS_W-1:0]        res_bits_r;
  logic [1:0]                res_err_r;
  logic [PRIO_W-1:0]         res_addr_r;
  logic                      res_addr_ok_r;
  logic                      res_credited_r;

  // ---------------------------------------------------------------------------
  // Decode of the latched command
  // ---------------------------------------------------------------------------
  logic                      pr_valid;
  logic [PRIO_W-1:0]         pr_idx;
  logic                      bad_prio;
  logic                      is_pop_cmd;
  logic                      q_full;
  logic [PRIO_W-1:0]         pop_q;
  logic                      pop_found;
  logic [PRIORITIES-1:0]     avail;
  logic [PRIORITIES-1:0]     credit;
  sel_t                      sel;

  assign pr_valid   = ({1'b0, pr_r} < 5'(PRIORITIES));
  assign pr_idx     = pr_r[PRIO_W-1:0];
  assign bad_prio   = !pr_valid && (cmd_r == CMD_INSERT || cmd_r == CMD_FORWARD ||
                                    cmd_r == CMD_POP_PRIO || cmd_r == CMD_QUERY);
  assign is_pop_cmd = (cmd_r == CMD_POP) || (cmd_r == CMD_POP_PRIO);
  assign q_full     = (count_r[pr_idx] == CNT_W'(QUEUE_DEPTH));

  always_comb begin
    for (int i = 0; i < PRIORITIES; i++) begin
      avail[i]  = (count_r[i] != '0);
      credit[i] = (count_r[i] != '0) && (fcnt_r[i] != '0);
    end
  end

  pfq_prio_select u_select (
    .avail     (avail),
    .credit    (credit),
    .nonstrict (nonstrict_r),
    .pop_only  (pop_only_r),
    .sel       (sel)
  );

  assign pop_q     = (cmd_r == CMD_POP) ? sel.q : pr_idx;
  assign pop_found = (cmd_r == CMD_POP) ? sel.found : avail[pr_idx];

  // ---------------------------------------------------------------------------
  // Frame RAM: one entry per (priority, slot)
  // ---------------------------------------------------------------------------
  logic                      mem_we;
  logic                      mem_re;
  logic [ENTRY_W-1:0]        rd_data;
  logic [STORE_TAG_W-1:0]    rd_tag;
  logic [FBITS_W-1:0]        rd_bits;

  pfq_frame_ram #(
    .DATA_W (ENTRY_W),
    .ADDR_W (ADDR_W)
  ) u_frame_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr ({pr_idx, tail_r[pr_idx]}),
    .wdata ({tag_r, fbits_r}),
    .re    (mem_re),
    .raddr ({pop_q, head_r[pop_q]}),
    .rdata (rd_data)
  );

  assign rd_bits = rd_data[FBITS_W-1:0];
  assign rd_tag  = rd_data[ENTRY_W-1:FBITS_W];

  // ---------------------------------------------------------------------------
  // Counter arithmetic
  // ---------------------------------------------------------------------------
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // clamp a 33-bit signed value into the signed 32-bit range
  function automatic logic signed [FWDB_W-1:0] sat_fwd(input logic signed [FWDB_W:0] v);
    if (v[FWDB_W] != v[FWDB_W-1]) begin
      sat_fwd = v[FWDB_W] ? {1'b1, {(FWDB_W-1){1'b0}}} : {1'b0, {(FWDB_W-1){1'b1}}};
    end else begin
      sat_fwd = v[FWDB_W-1:0];
    end
  endfunction

  logic [FCNT_W:0]           fwd_cnt_sum;
  logic [FCNT_W-1:0]         fwd_cnt_nxt;
  logic signed [FWDB_W:0]    fwd_add_sum;
  logic signed [FWDB_W-1:0]  fwd_add_nxt;
  logic signed [FWDB_W:0]    fwd_sub_sum;
  logic signed [FWDB_W-1:0]  fwd_sub_nxt;

  // forward: credit += current queue contents, both saturating
  assign fwd_cnt_sum = {1'b0, fcnt_r[pr_idx]} + (FCNT_W+1)'(count_r[pr_idx]);
  assign fwd_cnt_nxt = fwd_cnt_sum[FCNT_W] ? '1 : fwd_cnt_sum[FCNT_W-1:0];
  assign fwd_add_sum = {fwd_bits_r[pr_idx][FWDB_W-1], fwd_bits_r[pr_idx]} +
                       (FWDB_W+1)'(btot_r[pr_idx]);
  assign fwd_add_nxt = sat_fwd(fwd_add_sum);
  // credited pop: credit bits -= popped frame bits (may go negative)
  assign fwd_sub_sum = {fwd_bits_r[res_addr_r][FWDB_W-1], fwd_bits_r[res_addr_r]} -
                       (FWDB_W+1)'(rd_bits);
  assign fwd_sub_nxt = sat_fwd(fwd_sub_sum);

  // ---------------------------------------------------------------------------
  // Sequencer: IDLE -> EXEC -> (READ for a served pop) -> RESP
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (!bad_prio && is_pop_cmd && pop_found) state_nxt = ST_READ;
        else                                      state_nxt = ST_RESP;
      end
      ST_READ: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        state_nxt = start ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy       = 1'b0;
    out_strobe = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    case (state_r)
      ST_IDLE: begin
      end
      ST_EXEC: begin
        busy   = 1'b1;
        mem_we = (cmd_r == CMD_INSERT) && !bad_prio && !q_full;
        mem_re = is_pop_cmd && !bad_prio && pop_found;
      end
      ST_READ: begin
        busy = 1'b1;
      end
      ST_RESP: begin
        out_strobe = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // State registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      nonstrict_r  <= 1'b0;
      pop_only_r   <= 1'b0;
      total_cnt_r  <= '0;
      total_bits_r <= '0;
      for (int i = 0; i < PRIORITIES; i++) begin
        head_r[i]     <= '0;
        tail_r[i]     <= '0;
        count_r[i]    <= '0;
        btot_r[i]     <= '0;
        fcnt_r[i]     <= '0;
        fwd_bits_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;

      if (cfg_valid) begin
        case (cfg_index)
          CFG_NONSTRICT: nonstrict_r <= cfg_data;
          CFG_POP_ONLY:  pop_only_r  <= cfg_data;
          default: ;
        endcase
      end

      if (state_r == ST_EXEC && !bad_prio) begin
        case (cmd_r)
          CMD_INSERT: begin
            if (!q_full) begin
              tail_r[pr_idx]  <= ptr_inc(tail_r[pr_idx]);
              count_r[pr_idx] <= count_r[pr_idx] + CNT_W'(1);
              btot_r[pr_idx]  <= btot_r[pr_idx] + BT_W'(fbits_r);
              total_cnt_r     <= total_cnt_r + TC_W'(1);
              total_bits_r    <= total_bits_r + TB_W'(fbits_r);
            end
          end
          CMD_FORWARD: begin
            fcnt_r[pr_idx]     <= fwd_cnt_nxt;
            fwd_bits_r[pr_idx] <= fwd_add_nxt;
          end
          default: ;
        endcase
      end

      // popped frame arrives from the RAM: retire it from its queue
      if (state_r == ST_READ) begin
        head_r[res_addr_r]  <= ptr_inc(head_r[res_addr_r]);
        count_r[res_addr_r] <= count_r[res_addr_r] - CNT_W'(1);
        btot_r[res_addr_r]  <= btot_r[res_addr_r] - BT_W'(rd_bits);
        total_cnt_r         <= total_cnt_r - TC_W'(1);
        total_bits_r        <= total_bits_r - TB_W'(rd_bits);
        if (res_credited_r) begin
          fcnt_r[res_addr_r]     <= fcnt_r[res_addr_r] - FCNT_W'(1);
          fwd_bits_r[res_addr_r] <= fwd_sub_nxt;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command and result payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      cmd_r   <= in_cmd;
      pr_r    <= in_priority_req;
      tag_r   <= in_frame_tag[STORE_TAG_W-1:0];
      fbits_r <= in_frame_bits;
    end

    if (state_r == ST_EXEC) begin
      res_has_r      <= 1'b0;
      res_addr_r     <= pop_q;
      res_credited_r <= (cmd_r == CMD_POP) && sel.credited;
      if (bad_prio) begin
        res_err_r <= ERR_BAD_PRIO;
      end else if (cmd_r == CMD_INSERT && q_full) begin
        res_err_r <= ERR_FULL;
      end else begin
        res_err_r <= ERR_OK;
      end
      // CMD_POP reports the served queue only if one was found; unknown codes none
      res_addr_ok_r <= !bad_prio &&
                       (cmd_r == CMD_INSERT || cmd_r == CMD_FORWARD ||
                        cmd_r == CMD_POP_PRIO || cmd_r == CMD_QUERY ||
                        (cmd_r == CMD_POP && sel.found));
    end

    if (state_r == ST_READ) begin
      res_has_r  <= 1'b1;
      res_tag_r  <= rd_tag;
      res_bits_r <= rd_bits;
    end
  end

  // ---------------------------------------------------------------------------
  // Result ports: state registers are already updated during the strobe cycle
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  assign out_has_frame  = res_has_r;
  assign out_tag        = res_has_r ? TAG_PORT_W'(res_tag_r) : '0;
  assign out_bits       = res_has_r ? res_bits_r : '0;
  assign out_priority   = res_has_r ? 3'(res_addr_r) : '0;
  assign out_error_code = res_err_r;

  assign out_prio_count     = res_addr_ok_r ? 9'(count_r[res_addr_r]) : '0;
  assign out_prio_bit_total = res_addr_ok_r ? 22'(btot_r[res_addr_r]) : '0;
  assign out_prio_fwd_count = res_addr_ok_r ? fcnt_r[res_addr_r] : '0;
  assign out_prio_fwd_bits  = res_addr_ok_r ? fwd_bits_r[res_addr_r] : '0;

  assign out_total_count = 12'(total_cnt_r);
  assign out_total_bits  = 25'(total_bits_r);
  assign out_all_empty   = (total_cnt_r == '0);

endmodule
`default_nettype wire
